// ----- sv/ofe_pkg.sv -----
// Package for the overlapping frame extractor: payload structs, register
// indexes, opcodes, state enums and sizing constants. No dependencies.
package ofe_pkg;

  localparam int MaxLen      = 64;
  localparam int SampleWidth = 16;
  localparam int ValueWidth  = SampleWidth + 1;
  localparam int AddrWidth   = $clog2(MaxLen);
  localparam int LenWidth    = 7;
  localparam int PeriodWidth = 16;
  localparam int CntWidth    = 32;
  localparam int SumWidth    = SampleWidth + AddrWidth + 1;
  localparam int CfgIdxWidth = 2;
  localparam int CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] RegFrameLength = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegFramePeriod = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegCenterMode  = 2'd2;
  localparam logic [CfgIdxWidth-1:0] RegZeroMean    = 2'd3;

  localparam logic OpSample = 1'b0;
  localparam logic OpEnd    = 1'b1;

  typedef struct packed {
    logic                          op;
    logic signed [SampleWidth-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         last_in_frame;
    logic                         more_pending;
    logic                         no_frame;
  } out_item_t;

  // Command passed from the front end to the back end.
  typedef struct packed {
    logic                 no_frame;
    logic                 more_pending;
    logic [CntWidth-1:0]  start;   // sample index of frame element 0
    logic [CntWidth-1:0]  seen;    // samples_seen when the frame was issued
    logic [LenWidth-1:0]  len;
    logic [LenWidth-1:0]  lead;    // leading elements that lie before the data start
    logic                 mean_rm;
  } frame_cmd_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DECIDE
  } fe_state_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_SUM,
    BE_DIV,
    BE_EMIT,
    BE_NOFRAME
  } be_state_t;

  function automatic logic before32(logic [CntWidth-1:0] a, logic [CntWidth-1:0] b);
    logic [CntWidth-1:0] d;
    d = b - a;
    return (d != '0) && !d[CntWidth-1];
  endfunction

endpackage

// ----- sv/ofe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ofe_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/ofe_front.sv -----
// Front end: accepts transactions, writes samples, keeps the counters and
// decides which frames to issue. Depends on ofe_pkg.
module ofe_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  ofe_pkg::in_item_t                     in_data,
  input  logic [ofe_pkg::LenWidth-1:0]          seg_len,
  input  logic [ofe_pkg::PeriodWidth-1:0]       hop,
  input  logic                                  center_mode,
  input  logic                                  mean_rm,
  input  logic                                  be_busy,
  output logic                                  ram_we,
  output logic [ofe_pkg::AddrWidth-1:0]         ram_waddr,
  output logic [ofe_pkg::SampleWidth-1:0]       ram_wdata,
  output logic                                  cmd_valid,
  input  logic                                  cmd_ready,
  output ofe_pkg::frame_cmd_t                   cmd
);
  ofe_pkg::fe_state_t state_r, state_nxt;
  logic [ofe_pkg::CntWidth-1:0] seen_r, seen_nxt, anchor_r, anchor_nxt;
  logic ended_r, ended_nxt, op_r, op_nxt;
  logic [ofe_pkg::LenWidth-1:0] len;
  logic [ofe_pkg::LenWidth-1:0] half;
  logic [ofe_pkg::LenWidth-1:0] lead;
  logic [ofe_pkg::CntWidth-1:0] per, start, end_excl, anchor_adv;
  logic emit;

  always_comb begin
    if (seg_len == '0) begin
      len = ofe_pkg::LenWidth'(1);
    end else if (seg_len > ofe_pkg::LenWidth'(ofe_pkg::MaxLen)) begin
      len = ofe_pkg::LenWidth'(ofe_pkg::MaxLen);
    end else begin
      len = seg_len;
    end
    half = center_mode ? (len >> 1) : '0;
    // Elements of a frame whose start lies before sample zero read as zero.
    lead = (anchor_r < ofe_pkg::CntWidth'(half)) ?
           (half - anchor_r[ofe_pkg::LenWidth-1:0]) : '0;
    per = (hop == '0) ? ofe_pkg::CntWidth'(1) : ofe_pkg::CntWidth'(hop);
    start = anchor_r - ofe_pkg::CntWidth'(half);
    end_excl = start + ofe_pkg::CntWidth'(len);
    anchor_adv = anchor_r + per;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ofe_pkg::FE_IDLE;
      seen_r   <= '0;
      anchor_r <= '0;
      ended_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seen_r   <= seen_nxt;
      anchor_r <= anchor_nxt;
      ended_r  <= ended_nxt;
    end
    op_r <= op_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    seen_nxt   = seen_r;
    anchor_nxt = anchor_r;
    ended_nxt  = ended_r;
    op_nxt     = op_r;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = seen_r[ofe_pkg::AddrWidth-1:0];
    ram_wdata  = in_data.sample;
    cmd_valid  = 1'b0;
    emit       = 1'b0;
    cmd.no_frame     = 1'b0;
    cmd.more_pending = 1'b0;
    cmd.start        = start;
    cmd.seen         = seen_r;
    cmd.len          = len;
    cmd.lead         = lead;
    cmd.mean_rm      = mean_rm;
    case (state_r)
      ofe_pkg::FE_IDLE: begin
        // A new sample would overwrite the oldest store entry, so wait until
        // the back end has finished reading every issued frame.
        in_ready = !be_busy;
        if (in_valid && !be_busy) begin
          op_nxt = in_data.op;
          if (in_data.op == ofe_pkg::OpEnd) begin
            ended_nxt = 1'b1;
            state_nxt = ofe_pkg::FE_DECIDE;
          end else if (!ended_r) begin
            ram_we    = 1'b1;
            seen_nxt  = seen_r + 1'b1;
            state_nxt = ofe_pkg::FE_DECIDE;
          end
        end
      end
      ofe_pkg::FE_DECIDE: begin
        if (op_r == ofe_pkg::OpSample) begin
          emit = !ofe_pkg::before32(seen_r, end_excl);
          cmd_valid = emit;
        end else begin
          cmd_valid = 1'b1;
          emit = ofe_pkg::before32(anchor_r, seen_r);
          cmd.no_frame = !emit;
          cmd.more_pending = emit && ofe_pkg::before32(anchor_adv, seen_r);
        end
        if (!cmd_valid || cmd_ready) begin
          state_nxt = ofe_pkg::FE_IDLE;
          if (emit) begin
            anchor_nxt = anchor_adv;
          end
        end
      end
      default: state_nxt = ofe_pkg::FE_IDLE;
    endcase
  end
endmodule

// ----- sv/ofe_queue.sv -----
// Two-entry command queue between front and back end. Depends on ofe_pkg.
module ofe_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  ofe_pkg::frame_cmd_t  wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output ofe_pkg::frame_cmd_t  rd_data
);
  ofe_pkg::frame_cmd_t slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = slot_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
    end
    if (push) slot_r[wp_r] <= wr_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2) else $error("full queue lost an entry");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count did not follow a push");
`endif
endmodule

// ----- sv/ofe_back.sv -----
// Back end: reads frame samples from the store, forms the sum, divides for
// the mean and streams the frame out, or a no-frame marker. Depends on ofe_pkg.
module ofe_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cmd_valid,
  output logic                                  cmd_ready,
  input  ofe_pkg::frame_cmd_t                   cmd,
  output logic [ofe_pkg::AddrWidth-1:0]         ram_raddr,
  input  logic [ofe_pkg::SampleWidth-1:0]       ram_rdata,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ofe_pkg::out_item_t                    out_data
);
  localparam int SW = ofe_pkg::SumWidth;
  localparam int LW = ofe_pkg::LenWidth;
  localparam int DW = SW + 1;

  ofe_pkg::be_state_t state_r, state_nxt;
  ofe_pkg::frame_cmd_t cmd_r, cmd_nxt;
  logic [LW-1:0] rd_idx_r, rd_idx_nxt, got_r, got_nxt;
  logic rd_pend_r, rd_pend_nxt, rd_ok_r, rd_ok_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt, mean_r, mean_nxt;
  logic [DW-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [DW-1:0] divisor;
  logic [LW-1:0] div_cnt_r, div_cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  ofe_pkg::out_item_t out_r, out_nxt;
  logic [ofe_pkg::CntWidth-1:0] t_idx, age;
  logic rd_in_range;
  logic rd_pos;
  logic signed [ofe_pkg::SampleWidth-1:0] samp;
  logic signed [ofe_pkg::ValueWidth-1:0] val_calc;
  logic [DW-1:0] rem_sh;
  logic [DW-1:0] mag2;

  // Element validity: only samples received and still held in the store count.
  always_comb begin
    t_idx = cmd_r.start + ofe_pkg::CntWidth'(rd_idx_r);
    age   = cmd_r.seen - t_idx;
    rd_in_range = (age >= ofe_pkg::CntWidth'(1)) &&
                  (age <= ofe_pkg::CntWidth'(ofe_pkg::MaxLen));
  end

  // Elements before the data start read as zero.
  assign rd_pos = (rd_idx_r >= cmd_r.lead);

  assign ram_raddr = t_idx[ofe_pkg::AddrWidth-1:0];
  assign samp = rd_ok_r ? $signed(ram_rdata) : '0;
  assign divisor = {{(DW-LW-1){1'b0}}, cmd_r.len, 1'b0};
  assign rem_sh = {rem_r[DW-2:0], quo_r[DW-1]};
  assign mag2 = sum_r[SW-1] ? DW'(-sum_r) : DW'(sum_r);
  assign val_calc = ofe_pkg::ValueWidth'(samp) - ofe_pkg::ValueWidth'(mean_r);

  assign cmd_ready = (state_r == ofe_pkg::BE_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ofe_pkg::BE_IDLE;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
    cmd_r     <= cmd_nxt;
    rd_idx_r  <= rd_idx_nxt;
    got_r     <= got_nxt;
    rd_ok_r   <= rd_ok_nxt;
    sum_r     <= sum_nxt;
    mean_r    <= mean_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    div_cnt_r <= div_cnt_nxt;
    out_r     <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    rd_idx_nxt    = rd_idx_r;
    got_nxt       = got_r;
    rd_pend_nxt   = 1'b0;
    rd_ok_nxt     = rd_ok_r;
    sum_nxt       = sum_r;
    mean_nxt      = mean_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ofe_pkg::BE_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt    = cmd;
          rd_idx_nxt = '0;
          got_nxt    = '0;
          sum_nxt    = '0;
          mean_nxt   = '0;
          state_nxt  = cmd.no_frame ? ofe_pkg::BE_NOFRAME : ofe_pkg::BE_SUM;
        end
      end
      ofe_pkg::BE_SUM: begin
        // One read a cycle; data lands in the next cycle.
        if (rd_pend_r) begin
          sum_nxt = sum_r + SW'(samp);
          got_nxt = got_r + 1'b1;
        end
        if (rd_idx_r < cmd_r.len) begin
          rd_ok_nxt   = rd_in_range && rd_pos;
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end else if (!rd_pend_r) begin
          rd_idx_nxt = '0;
          if (cmd_r.mean_rm) begin
            // (2|sum| + L) / (2L), restoring, one bit a cycle.
            quo_nxt     = {mag2[DW-2:0], 1'b0} + DW'(cmd_r.len);
            rem_nxt     = '0;
            div_cnt_nxt = '0;
            state_nxt   = ofe_pkg::BE_DIV;
          end else begin
            state_nxt = ofe_pkg::BE_EMIT;
          end
        end
      end
      ofe_pkg::BE_DIV: begin
        if (rem_sh >= divisor) begin
          rem_nxt = rem_sh - divisor;
          quo_nxt = {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[DW-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == LW'(DW - 1)) begin
          mean_nxt  = sum_r[SW-1] ? -SW'(quo_nxt) : SW'(quo_nxt);
          state_nxt = ofe_pkg::BE_EMIT;
        end
      end
      ofe_pkg::BE_EMIT: begin
        // Reread each element; rd_pend_r marks registered data ready.
        if (rd_pend_r) begin
          out_valid_nxt = 1'b1;
          out_nxt.value = val_calc;
          out_nxt.last_in_frame = (rd_idx_r == cmd_r.len);
          out_nxt.more_pending  = cmd_r.more_pending;
          out_nxt.no_frame      = 1'b0;
          if (rd_idx_r == cmd_r.len) state_nxt = ofe_pkg::BE_IDLE;
        end else if (!out_valid_nxt) begin
          rd_ok_nxt   = rd_in_range && rd_pos;
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end
      end
      ofe_pkg::BE_NOFRAME: begin
        if (!out_valid_nxt) begin
          out_valid_nxt = 1'b1;
          out_nxt.value = '0;
          out_nxt.last_in_frame = 1'b0;
          out_nxt.more_pending  = 1'b0;
          out_nxt.no_frame      = 1'b1;
          state_nxt = ofe_pkg::BE_IDLE;
        end
      end
      default: state_nxt = ofe_pkg::BE_IDLE;
    endcase
  end

  // The t_idx read address is computed from rd_idx_r before increment, so
  // rd_idx_r already points past the element whose data is returning.

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_r))
    else $error("result changed while stalled");
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_ready |-> state_r == ofe_pkg::BE_IDLE) else $error("ready outside idle");
  a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ofe_pkg::BE_EMIT) |-> (cmd_r.len != '0 && rd_idx_r <= cmd_r.len))
    else $error("element index past frame length");
`endif
endmodule

// ----- sv/overlapping_frame_extractor_unit.sv -----
// Top level of the overlapping frame extractor: config registers, front end,
// command queue, sample store and back end. Depends on ofe_pkg and submodules.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_ready  | ofe_pkg::in_item_t
//   out_    | output    | out_valid/out_ready| ofe_pkg::out_item_t
//   cfg_    | input     | cfg_we             | cfg_idx, cfg_wdata
//
// A transaction passes the front end's idle and decide states. A frame is
// summed, divided for the mean with mean removal on, then streamed: each
// element is reread once the previous result has been taken. Reset is
// synchronous; the store is not cleared, reads outside the received window
// return zero. A new transaction is taken only once the queue is empty and
// the back end is idle, so output stalls hold off in_ready.
module overlapping_frame_extractor_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ofe_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ofe_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [ofe_pkg::CfgIdxWidth-1:0]      cfg_idx,
  input  logic [ofe_pkg::CfgDataWidth-1:0]     cfg_wdata
);
  logic [ofe_pkg::LenWidth-1:0]    seg_len_r;
  logic [ofe_pkg::PeriodWidth-1:0] hop_r;
  logic center_mode_r, mean_rm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r     <= ofe_pkg::LenWidth'(64);
      hop_r         <= ofe_pkg::PeriodWidth'(16);
      center_mode_r <= 1'b1;
      mean_rm_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        ofe_pkg::RegFrameLength: seg_len_r     <= cfg_wdata[ofe_pkg::LenWidth-1:0];
        ofe_pkg::RegFramePeriod: hop_r         <= cfg_wdata;
        ofe_pkg::RegCenterMode:  center_mode_r <= cfg_wdata[0];
        ofe_pkg::RegZeroMean:    mean_rm_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic ram_we;
  logic [ofe_pkg::AddrWidth-1:0] ram_waddr, ram_raddr;
  logic [ofe_pkg::SampleWidth-1:0] ram_wdata, ram_rdata;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  logic be_busy;
  ofe_pkg::frame_cmd_t fq_cmd, qb_cmd;

  assign be_busy = qb_valid || !qb_ready;

  ofe_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .seg_len(seg_len_r), .hop(hop_r),
    .center_mode(center_mode_r), .mean_rm(mean_rm_r), .be_busy,
    .ram_we, .ram_waddr, .ram_wdata,
    .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
  );

  ofe_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
  );

  ofe_ram #(.Width(ofe_pkg::SampleWidth), .Depth(ofe_pkg::MaxLen)) u_store (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  ofe_back u_back (
    .clk, .rst_n, .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
    .ram_raddr, .ram_rdata, .out_valid, .out_ready, .out_data
  );
endmodule

// ----- bench/ofe_checker.sv -----
// Checker for the overlapping frame extractor: watches the config port and both
// channels, predicts every result frame and compares. Depends on ofe_pkg.
`timescale 1ns / 100ps

module ofe_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  ofe_pkg::in_item_t                   in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  ofe_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [ofe_pkg::CfgIdxWidth-1:0]     cfg_idx,
  input  logic [ofe_pkg::CfgDataWidth-1:0]    cfg_wdata,
  input  logic                                run_done,
  output int                                  errors,
  output int                                  pending
);

  logic [ofe_pkg::LenWidth-1:0]    cur_len;
  logic [ofe_pkg::PeriodWidth-1:0] cur_period;
  logic                            cur_center;
  logic                            cur_mean_rm;

  logic signed [ofe_pkg::SampleWidth-1:0] history [ofe_pkg::MaxLen];
  logic [ofe_pkg::CntWidth-1:0] seen_cnt;
  logic [ofe_pkg::CntWidth-1:0] anchor;
  logic                         ended;
  logic                         done_seen;
  ofe_pkg::out_item_t           frame_q [$];

  function automatic logic precedes(logic [ofe_pkg::CntWidth-1:0] a,
                                    logic [ofe_pkg::CntWidth-1:0] b);
    logic [ofe_pkg::CntWidth-1:0] d;
    d = b - a;
    return (d != 0) && !d[ofe_pkg::CntWidth-1];
  endfunction

  function automatic int eff_len();
    if (cur_len == 0) return 1;
    if (cur_len > ofe_pkg::MaxLen) return ofe_pkg::MaxLen;
    return int'(cur_len);
  endfunction

  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Queues one whole frame at the current anchor and advances the anchor.
  task automatic push_frame(input logic draining);
    int len, c;
    longint vals [ofe_pkg::MaxLen];
    longint total, mag, q, mean;
    logic [ofe_pkg::CntWidth-1:0] t, d;
    logic more;
    ofe_pkg::out_item_t e;
    len = eff_len();
    c = cur_center ? len / 2 : 0;
    total = 0;
    for (int i = 0; i < len; i++) begin
      vals[i] = 0;
      if (!(i < c && ofe_pkg::CntWidth'(c - i) > anchor)) begin
        t = anchor - ofe_pkg::CntWidth'(c) + ofe_pkg::CntWidth'(i);
        d = seen_cnt - t;
        if (d >= 1 && d <= ofe_pkg::MaxLen) vals[i] = history[t[ofe_pkg::AddrWidth-1:0]];
      end
      total += vals[i];
    end
    mean = 0;
    if (cur_mean_rm) begin
      mag = (total < 0) ? -total : total;
      q = (2 * mag + len) / (2 * len);
      mean = (total < 0) ? -q : q;
    end
    anchor += (cur_period == 0) ? 1 : cur_period;
    more = draining && precedes(anchor, seen_cnt);
    for (int i = 0; i < len; i++) begin
      e.value = ofe_pkg::ValueWidth'(vals[i] - mean);
      e.last_in_frame = (i == len - 1);
      e.more_pending = more;
      e.no_frame = 1'b0;
      frame_q.push_back(e);
    end
  endtask

  task automatic predict(input ofe_pkg::in_item_t it);
    int len, c;
    logic [ofe_pkg::CntWidth-1:0] end_excl;
    ofe_pkg::out_item_t e;
    if (it.op == ofe_pkg::OpSample) begin
      if (!ended) begin
        history[seen_cnt[ofe_pkg::AddrWidth-1:0]] = it.sample;
        seen_cnt++;
        len = eff_len();
        c = cur_center ? len / 2 : 0;
        end_excl = anchor - ofe_pkg::CntWidth'(c) + ofe_pkg::CntWidth'(len);
        if (!precedes(seen_cnt, end_excl)) push_frame(1'b0);
      end
    end else begin
      ended = 1'b1;
      if (!precedes(anchor, seen_cnt)) begin
        e = '0;
        e.no_frame = 1'b1;
        frame_q.push_back(e);
      end else begin
        push_frame(1'b1);
      end
    end
  endtask

  task automatic compare(input ofe_pkg::out_item_t got);
    ofe_pkg::out_item_t want;
    if (frame_q.size() == 0) begin
      report($sformatf("unexpected result value %0d", got.value));
    end else begin
      want = frame_q.pop_front();
      check_field("value", got.value, want.value);
      check_field("last_in_frame", got.last_in_frame, want.last_in_frame);
      check_field("more_pending", got.more_pending, want.more_pending);
      check_field("no_frame", got.no_frame, want.no_frame);
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_len = 7'd64;
      cur_period = 16'd16;
      cur_center = 1'b1;
      cur_mean_rm = 1'b0;
      for (int i = 0; i < ofe_pkg::MaxLen; i++) history[i] = '0;
      seen_cnt = '0;
      anchor = '0;
      ended = 1'b0;
      done_seen = 1'b0;
      frame_q.delete();
    end else begin
      if (out_valid && out_ready) compare(out_data);
      if (cfg_we) begin
        case (cfg_idx)
          ofe_pkg::RegFrameLength: cur_len = cfg_wdata[ofe_pkg::LenWidth-1:0];
          ofe_pkg::RegFramePeriod: cur_period = cfg_wdata[ofe_pkg::PeriodWidth-1:0];
          ofe_pkg::RegCenterMode:  cur_center = cfg_wdata[0];
          ofe_pkg::RegZeroMean:    cur_mean_rm = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict(in_data);
      if (run_done && !done_seen) begin
        done_seen = 1'b1;
        if (frame_q.size() != 0) begin
          report($sformatf("%0d results never arrived", frame_q.size()));
        end
      end
    end
    pending = frame_q.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the frame extractor testbench: clock, reset, stimulus, result-side
// stalls, watchdog and verdict. Depends on ofe_pkg, ofe_checker and the block.
`timescale 1ns / 100ps

module testbench;

  localparam int StallLimit = 5000;
  localparam int SettleCycles = 300;
  localparam int HoldCycles = 800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ofe_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ofe_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [ofe_pkg::CfgIdxWidth-1:0] cfg_idx = '0;
  logic [ofe_pkg::CfgDataWidth-1:0] cfg_wdata = '0;
  logic run_done = 1'b0;
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;
  int errors;
  int pending;
  int quiet_cycles = 0;

  overlapping_frame_extractor_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  ofe_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .run_done(run_done), .errors(errors), .pending(pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [ofe_pkg::SampleWidth-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sd32767;
      2: return '0;
      3: return -16'sd1;
      default: return ofe_pkg::SampleWidth'($urandom);
    endcase
  endfunction

  task automatic send(input logic op, input logic signed [ofe_pkg::SampleWidth-1:0] s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.op <= op;
    in_data.sample <= s;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Waits until every expected result has arrived, then lets the block settle
  // in case it is still working on a sample that produces nothing.
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_config(input int len, input int period, input logic center,
                              input logic mean_rm);
    quiesce();
    cfg_we <= 1'b1;
    cfg_idx <= ofe_pkg::RegFrameLength;
    cfg_wdata <= ofe_pkg::CfgDataWidth'(len);
    @(posedge clk);
    cfg_idx <= ofe_pkg::RegFramePeriod;
    cfg_wdata <= ofe_pkg::CfgDataWidth'(period);
    @(posedge clk);
    cfg_idx <= ofe_pkg::RegCenterMode;
    cfg_wdata <= ofe_pkg::CfgDataWidth'(center);
    @(posedge clk);
    cfg_idx <= ofe_pkg::RegZeroMean;
    cfg_wdata <= ofe_pkg::CfgDataWidth'(mean_rm);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls per result and one long hold-off on request.
  initial begin
    int gap;
    logic held;
    held = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  initial begin
    int len, period;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Length and period of zero act as one: every sample is a frame of its own.
    write_config(0, 0, 1'b0, 1'b0);
    send(ofe_pkg::OpSample, 16'sh8000);
    send(ofe_pkg::OpSample, 16'sd32767);
    send(ofe_pkg::OpSample, 16'sd0);
    send(ofe_pkg::OpSample, -16'sd1);
    send(ofe_pkg::OpSample, 16'sd1);
    send(ofe_pkg::OpSample, 16'sh5555);
    send(ofe_pkg::OpSample, 16'shAAAA);
    // Oversized length is clipped to the store depth; old samples read as zero.
    write_config(127, 3, 1'b1, 1'b1);
    for (int i = 0; i < 9; i++) begin
      send(ofe_pkg::OpSample, (i % 2) ? 16'sd32767 : 16'sh8000);
    end
    write_config(64, 1, 1'b1, 1'b1);
    for (int i = 0; i < 8; i++) send(ofe_pkg::OpSample, 16'sh8000);

    for (int ph = 0; ph < 8; ph++) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 127) : $urandom_range(1, 24);
      period = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
      if (ph == 4) begin
        len = 64;
        period = 2;
      end
      write_config(len, period, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      no_idle <= (ph % 3 == 1);
      if (ph == 4) hold_req <= 1'b1;
      for (int i = 0; i < 40; i++) send(ofe_pkg::OpSample, pick_sample());
    end

    // End of stream: drain with several frames pending, then jump the anchor
    // past all data so the remaining drains find nothing.
    write_config(64, 4, 1'b1, 1'b1);
    no_idle <= 1'b0;
    for (int i = 0; i < 40; i++) send(ofe_pkg::OpSample, pick_sample());
    for (int i = 0; i < 3; i++) send(ofe_pkg::OpEnd, pick_sample());
    write_config(64, 65535, 1'b0, 1'b0);
    for (int i = 0; i < 3; i++) send(ofe_pkg::OpEnd, '0);
    send(ofe_pkg::OpSample, 16'sd1234);
    send(ofe_pkg::OpSample, -16'sd1234);
    send(ofe_pkg::OpEnd, '0);

    quiesce();
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/ofe_pkg.sv
sv/ofe_ram.sv
sv/ofe_front.sv
sv/ofe_queue.sv
sv/ofe_back.sv
sv/overlapping_frame_extractor_unit.sv
bench/ofe_checker.sv
bench/testbench.sv
